// ===== hdl/rkf_pkg.sv =====
package rkf_pkg;

  // Default geometry limits
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;

  // Field and register widths
  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int KS_W       = 2;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int SUM_W      = 13;
  localparam int TAPS       = 9;

  // Register reset values
  localparam logic [WIDTH_W-1:0]  RST_IMAGE_WIDTH  = WIDTH_W'(1024);
  localparam logic [HEIGHT_W-1:0] RST_IMAGE_HEIGHT = HEIGHT_W'(4096);
  localparam logic [WIDTH_W-1:0]  RST_REGION_X_END = WIDTH_W'(1024);
  localparam logic [HEIGHT_W-1:0] RST_REGION_Y_END = HEIGHT_W'(4096);

  // Input item kinds
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  // Output queue
  localparam int OUTQ_DEPTH = 8;
  localparam int OUTQ_AW    = 3;

  // Divide by 9 as multiply by reciprocal; exact for sums below 32768
  localparam int                RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] BOX_RECIP  = RECIP_W'(7282);
  localparam int                BOX_SHIFT   = 16;
  localparam int                GAUSS_SHIFT = 4;
  localparam logic [CH_W-1:0]    CH_MAX     = 8'd255;

  typedef enum logic [KS_W-1:0] {
    KS_SHARPEN,
    KS_EDGE,
    KS_BOX,
    KS_GAUSS
  } kernel_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL_SELECT,
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_REGION_X_START,
    REG_REGION_X_END,
    REG_REGION_Y_START,
    REG_REGION_Y_END
  } reg_index_t;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef pixel_t [TAPS-1:0] window_t;
  typedef logic [TAPS-1:0][CH_W-1:0] chan_win_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  // Line store stage control
  typedef struct packed {
    logic push;
    logic emit;
    logic in_region;
  } stage_tag_t;

  // Arithmetic stage control
  typedef struct packed {
    logic valid;
    logic in_region;
  } result_tag_t;

  // Kernel weights, row-major, top-left first
  localparam logic signed [4:0] KERNEL_W [4][TAPS] = '{
    '{5'sd0,  -5'sd1, 5'sd0,  -5'sd1, 5'sd5, -5'sd1, 5'sd0,  -5'sd1, 5'sd0},
    '{-5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd8, -5'sd1, -5'sd1, -5'sd1, -5'sd1},
    '{5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1, 5'sd1,  5'sd1,  5'sd1,  5'sd1},
    '{5'sd1,  5'sd2,  5'sd1,  5'sd2,  5'sd4, 5'sd2,  5'sd1,  5'sd2,  5'sd1}
  };

  // Weighted 3x3 sum of one channel
  function automatic sum_t conv_sum(input kernel_t ks, input chan_win_t px);
    sum_t acc;
    acc = '0;
    for (int k = 0; k < TAPS; k++) begin
      acc = acc + SUM_W'(KERNEL_W[ks][k]) * SUM_W'($signed({1'b0, px[k]}));
    end
    return acc;
  endfunction

  // Zero on negative, divide by the kernel's norm, limit to full scale
  function automatic logic [CH_W-1:0] scale_clamp(input kernel_t ks, input sum_t s);
    logic [SUM_W-2:0]         mag;
    logic [SUM_W-2+RECIP_W:0] prod;
    logic [SUM_W-2:0]         q;
    logic [CH_W-1:0]          res;
    mag  = s[SUM_W-2:0];
    prod = (SUM_W-1+RECIP_W)'(mag) * (SUM_W-1+RECIP_W)'(BOX_RECIP);
    case (ks)
      KS_BOX:   q = (SUM_W-1)'(prod >> BOX_SHIFT);
      KS_GAUSS: q = mag >> GAUSS_SHIFT;
      default:  q = mag;
    endcase
    if (s[SUM_W-1]) begin
      res = '0;
    end else if (q > (SUM_W-1)'(CH_MAX)) begin
      res = CH_MAX;
    end else begin
      res = q[CH_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== hdl/rkf_ram.sv =====
module rkf_ram #(
  parameter int WIDTH = rkf_pkg::PIX_W,
  parameter int DEPTH = rkf_pkg::DEF_MAX_WIDTH
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/rkf_ctrl.sv =====
module rkf_ctrl #(
  parameter int MAX_WIDTH  = rkf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rkf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             accept,
  input  logic                             mode,
  input  rkf_pkg::pixel_t                  pix_in,
  input  logic [rkf_pkg::WIDTH_W-1:0]      image_width,
  input  logic [rkf_pkg::HEIGHT_W-1:0]     image_height,
  input  logic [rkf_pkg::WIDTH_W-1:0]      region_x_start,
  input  logic [rkf_pkg::WIDTH_W-1:0]      region_x_end,
  input  logic [rkf_pkg::HEIGHT_W-1:0]     region_y_start,
  input  logic [rkf_pkg::HEIGHT_W-1:0]     region_y_end,
  output logic                             rd_en,
  output logic [$clog2(MAX_WIDTH)-1:0]     rd_addr,
  output rkf_pkg::stage_tag_t              s1_tag,
  output logic [$clog2(MAX_WIDTH)-1:0]     s1_addr,
  output rkf_pkg::pixel_t                  s1_pix
);
  import rkf_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int XW = ((CW > WIDTH_W) ? CW : WIDTH_W) + 1;
  localparam int YW = ((RW > HEIGHT_W) ? RW : HEIGHT_W) + 1;
  localparam int PW = $clog2(MAX_WIDTH + 2);

  logic [CW-1:0] in_col, in_col_next, out_col, out_col_next;
  logic [RW-1:0] in_row, in_row_next, out_row, out_row_next;
  logic [PW-1:0] pend, pend_next;

  logic [XW-1:0] ew, xs, xe, lag, pend_x, in_c1, out_c1;
  logic [YW-1:0] eh, ys, ye, in_r1, out_r1;
  logic [CW-1:0] in_col_adv, out_col_adv;
  logic [RW-1:0] in_row_adv, out_row_adv;
  logic          is_pix, push, emit, in_region;

  // Effective frame size and clipped region
  always_comb begin
    if (image_width == '0) begin
      ew = XW'(1);
    end else if (XW'(image_width) > XW'(MAX_WIDTH)) begin
      ew = XW'(MAX_WIDTH);
    end else begin
      ew = XW'(image_width);
    end
    if (image_height == '0) begin
      eh = YW'(1);
    end else if (YW'(image_height) > YW'(MAX_HEIGHT)) begin
      eh = YW'(MAX_HEIGHT);
    end else begin
      eh = YW'(image_height);
    end
    xs = (region_x_start == '0) ? XW'(1) : XW'(region_x_start);
    xe = (XW'(region_x_end) >= ew) ? ew - XW'(1) : XW'(region_x_end);
    ys = (region_y_start == '0) ? YW'(1) : YW'(region_y_start);
    ye = (YW'(region_y_end) >= eh) ? eh - YW'(1) : YW'(region_y_end);
  end

  // Raster advance of the input and output positions
  always_comb begin
    in_c1       = XW'(in_col) + XW'(1);
    in_r1       = YW'(in_row) + YW'(1);
    in_col_adv  = (in_c1 >= ew) ? '0 : in_c1[CW-1:0];
    in_row_adv  = in_row;
    if (in_c1 >= ew) begin
      in_row_adv = (in_r1 >= eh) ? '0 : in_r1[RW-1:0];
    end
    out_c1      = XW'(out_col) + XW'(1);
    out_r1      = YW'(out_row) + YW'(1);
    out_col_adv = (out_c1 >= ew) ? '0 : out_c1[CW-1:0];
    out_row_adv = out_row;
    if (out_c1 >= ew) begin
      out_row_adv = (out_r1 >= eh) ? '0 : out_r1[RW-1:0];
    end
  end

  // Decide push and result for the item taken this cycle
  always_comb begin
    lag       = ew + XW'(1);
    pend_x    = XW'(pend);
    is_pix    = (mode == MODE_PIXEL);
    push      = accept && (is_pix || pend != '0);
    emit      = accept && (is_pix ? (pend_x >= lag) : (pend != '0));
    in_region = XW'(out_col) >= xs && XW'(out_col) < xe &&
                YW'(out_row) >= ys && YW'(out_row) < ye;

    in_col_next  = in_col;
    in_row_next  = in_row;
    out_col_next = out_col;
    out_row_next = out_row;
    pend_next    = pend;
    if (push) begin
      in_col_next = in_col_adv;
      in_row_next = in_row_adv;
    end
    if (emit) begin
      out_col_next = out_col_adv;
      out_row_next = out_row_adv;
    end
    if (accept && is_pix) begin
      pend_next = (pend_x >= lag) ? lag[PW-1:0] : pend + PW'(1);
    end else if (push) begin
      pend_next = pend - PW'(1);
      // last pending result leaves: realign input to output
      if (pend == PW'(1)) begin
        in_col_next = out_col_adv;
        in_row_next = out_row_adv;
      end
    end
  end

  assign rd_en   = push;
  assign rd_addr = in_col;

  // Hold positions and hand the item to the line store stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      pend    <= '0;
      s1_tag  <= '0;
    end else begin
      in_col  <= in_col_next;
      in_row  <= in_row_next;
      out_col <= out_col_next;
      out_row <= out_row_next;
      pend    <= pend_next;
      s1_tag  <= '{push: push, emit: emit, in_region: in_region};
    end
    s1_addr <= in_col;
    s1_pix  <= is_pix ? pix_in : '0;
  end

endmodule

// ===== hdl/rkf_window.sv =====
module rkf_window #(
  parameter int MAX_WIDTH = rkf_pkg::DEF_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  input  rkf_pkg::stage_tag_t          s1_tag,
  input  logic [$clog2(MAX_WIDTH)-1:0] s1_addr,
  input  rkf_pkg::pixel_t              s1_pix,
  output rkf_pkg::window_t             win,
  output rkf_pkg::result_tag_t         s2_tag
);
  import rkf_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  pixel_t        up_rd, mid_rd, up_cur, mid_cur;
  logic          fw_valid;
  logic [CW-1:0] fw_addr;
  pixel_t        fw_up, fw_mid;
  window_t       win_next;

  // Two line stores: upper row and middle row of each column
  rkf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk     (clk),
    .wr_en   (s1_tag.push),
    .wr_addr (s1_addr),
    .wr_data (mid_cur),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (up_rd)
  );

  rkf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk     (clk),
    .wr_en   (s1_tag.push),
    .wr_addr (s1_addr),
    .wr_data (s1_pix),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (mid_rd)
  );

  // Forward the write that landed in the same cycle as our read
  always_comb begin
    if (fw_valid && fw_addr == s1_addr) begin
      up_cur  = fw_up;
      mid_cur = fw_mid;
    end else begin
      up_cur  = up_rd;
      mid_cur = mid_rd;
    end
  end

  // Shift the window left and load the new column
  always_comb begin
    win_next = win;
    for (int r = 0; r < 3; r++) begin
      win_next[r*3]   = win[r*3+1];
      win_next[r*3+1] = win[r*3+2];
    end
    win_next[2] = up_cur;
    win_next[5] = mid_cur;
    win_next[8] = s1_pix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fw_valid <= 1'b0;
      win      <= '0;
      s2_tag   <= '0;
    end else begin
      fw_valid <= s1_tag.push;
      if (s1_tag.push) begin
        win <= win_next;
      end
      s2_tag <= '{valid: s1_tag.push && s1_tag.emit, in_region: s1_tag.in_region};
    end
    fw_addr <= s1_addr;
    fw_up   <= mid_cur;
    fw_mid  <= s1_pix;
  end

endmodule

// ===== hdl/rkf_arith.sv =====
module rkf_arith (
  input  logic                 clk,
  input  logic                 rst,
  input  rkf_pkg::kernel_t     kernel_select,
  input  rkf_pkg::result_tag_t s2_tag,
  input  rkf_pkg::window_t     win,
  output logic                 res_valid,
  output rkf_pkg::pixel_t      res_pix,
  output logic                 res_filtered
);
  import rkf_pkg::*;

  chan_win_t red_w, green_w, blue_w;
  logic      s3_valid, s3_inside;
  sum_t      s3_red, s3_green, s3_blue;
  pixel_t    s3_ctr;

  // Split the window into channels
  always_comb begin
    for (int k = 0; k < TAPS; k++) begin
      red_w[k]   = win[k][3*CH_W-1:2*CH_W];
      green_w[k] = win[k][2*CH_W-1:CH_W];
      blue_w[k]  = win[k][CH_W-1:0];
    end
  end

  // Register weighted sums and the center pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_tag.valid;
    end
    s3_inside <= s2_tag.in_region;
    s3_red    <= conv_sum(kernel_select, red_w);
    s3_green  <= conv_sum(kernel_select, green_w);
    s3_blue   <= conv_sum(kernel_select, blue_w);
    s3_ctr    <= win[4];
  end

  // Normalize, or pass the original pixel outside the region
  assign res_valid    = s3_valid;
  assign res_filtered = s3_inside;
  assign res_pix      = s3_inside ? {scale_clamp(kernel_select, s3_red),
                                     scale_clamp(kernel_select, s3_green),
                                     scale_clamp(kernel_select, s3_blue)}
                                  : s3_ctr;

endmodule

// ===== hdl/rgb_3x3_kernel_filter_top.sv =====
// 3x3 kernel filter on an RGB pixel stream in raster order.
// Input channel: in_valid/in_stall with mode, red_in, green_in, blue_in.
// mode 0 delivers a pixel; mode 1 is a flush tick that drains one
// delayed result at the end of a frame (a tick with nothing pending is
// taken and gives nothing).
// Output channel: out_valid/out_stall with red_out, green_out, blue_out
// and was_filtered.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; write
// only while the block is idle. cfg_ready is always high.
// Results lag the pixel stream by image_width+1 items. The result an item
// releases is registered in the line store stage, the window stage and the
// arithmetic stage, enters the output queue and can transfer out next cycle.
// Throughput is one item per clock while in_stall is low: the line stores
// are read in the transfer cycle and written in the cycle after, with
// forwarding across the registered read port.
// An 8-entry output queue absorbs the pipeline; in_stall rises when queue
// plus in-flight results could fill it, so a stalled receiver holds the
// sender before the queue overflows.
// Reset clears positions, pending count, window and queue and restores the
// register defaults. Line stores are not cleared; no clearing pass.
module rgb_3x3_kernel_filter_top #(
  parameter int MAX_WIDTH  = rkf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rkf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              mode,
  input  logic [rkf_pkg::CH_W-1:0]          red_in,
  input  logic [rkf_pkg::CH_W-1:0]          green_in,
  input  logic [rkf_pkg::CH_W-1:0]          blue_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rkf_pkg::CH_W-1:0]          red_out,
  output logic [rkf_pkg::CH_W-1:0]          green_out,
  output logic [rkf_pkg::CH_W-1:0]          blue_out,
  output logic                              was_filtered,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rkf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rkf_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import rkf_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  typedef struct packed {
    pixel_t pix;
    logic   filtered;
  } out_item_t;

  kernel_t             kernel_select;
  logic [WIDTH_W-1:0]  image_width, region_x_start, region_x_end;
  logic [HEIGHT_W-1:0] image_height, region_y_start, region_y_end;

  logic          accept;
  logic          rd_en;
  logic [CW-1:0] rd_addr, s1_addr;
  stage_tag_t    s1_tag;
  pixel_t        s1_pix;
  window_t       win;
  result_tag_t   s2_tag;
  logic          res_valid, res_filtered;
  pixel_t        res_pix;

  out_item_t            q_mem [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0]   wr_ptr, rd_ptr;
  logic [OUTQ_AW:0]     q_count;
  logic                 q_push, q_pop;
  logic [1:0]           inflight;
  logic [OUTQ_AW+1:0]   occupancy;
  out_item_t            q_head;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_select  <= KS_SHARPEN;
      image_width    <= RST_IMAGE_WIDTH;
      image_height   <= RST_IMAGE_HEIGHT;
      region_x_start <= '0;
      region_x_end   <= RST_REGION_X_END;
      region_y_start <= '0;
      region_y_end   <= RST_REGION_Y_END;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KERNEL_SELECT:  kernel_select  <= kernel_t'(cfg_data[KS_W-1:0]);
        REG_IMAGE_WIDTH:    image_width    <= cfg_data[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT:   image_height   <= cfg_data[HEIGHT_W-1:0];
        REG_REGION_X_START: region_x_start <= cfg_data[WIDTH_W-1:0];
        REG_REGION_X_END:   region_x_end   <= cfg_data[WIDTH_W-1:0];
        REG_REGION_Y_START: region_y_start <= cfg_data[HEIGHT_W-1:0];
        REG_REGION_Y_END:   region_y_end   <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input transfer, throttled by queue space
  assign inflight  = 2'(s1_tag.push && s1_tag.emit) + 2'(s2_tag.valid) + 2'(res_valid);
  assign occupancy = (OUTQ_AW+2)'(q_count) + (OUTQ_AW+2)'(inflight);
  assign in_stall  = occupancy > (OUTQ_AW+2)'(OUTQ_DEPTH - 1);
  assign accept    = in_valid && !in_stall;

  rkf_ctrl #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .mode           (mode),
    .pix_in         ({red_in, green_in, blue_in}),
    .image_width    (image_width),
    .image_height   (image_height),
    .region_x_start (region_x_start),
    .region_x_end   (region_x_end),
    .region_y_start (region_y_start),
    .region_y_end   (region_y_end),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .s1_tag         (s1_tag),
    .s1_addr        (s1_addr),
    .s1_pix         (s1_pix)
  );

  rkf_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .s1_tag  (s1_tag),
    .s1_addr (s1_addr),
    .s1_pix  (s1_pix),
    .win     (win),
    .s2_tag  (s2_tag)
  );

  rkf_arith u_arith (
    .clk           (clk),
    .rst           (rst),
    .kernel_select (kernel_select),
    .s2_tag        (s2_tag),
    .win           (win),
    .res_valid     (res_valid),
    .res_pix       (res_pix),
    .res_filtered  (res_filtered)
  );

  // Output queue
  assign q_push = res_valid;
  assign q_pop  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem[wr_ptr] <= '{pix: res_pix, filtered: res_filtered};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (q_push) begin
        wr_ptr <= wr_ptr + OUTQ_AW'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + OUTQ_AW'(1);
      end
      q_count <= q_count + (OUTQ_AW+1)'(q_push) - (OUTQ_AW+1)'(q_pop);
    end
  end

  assign q_head       = q_mem[rd_ptr];
  assign out_valid    = (q_count != '0);
  assign red_out      = q_head.pix[3*CH_W-1:2*CH_W];
  assign green_out    = q_head.pix[2*CH_W-1:CH_W];
  assign blue_out     = q_head.pix[CH_W-1:0];
  assign was_filtered = q_head.filtered;

  // Queue never takes a result it has no room for
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_count < (OUTQ_AW+1)'(OUTQ_DEPTH)) || q_pop)
    else $error("output queue overflow");

  // Every result comes from an item that released one, through the window stage
  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $past(s1_tag.push && s1_tag.emit, 2))
    else $error("result without a releasing item");

  // A pixel transfer always enters the line store stage
  a_pixel_pushes: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == MODE_PIXEL) |=> s1_tag.push)
    else $error("pixel not pushed into line stores");

endmodule

// ===== tb/rkf_checker.sv =====
module rkf_checker #(
  parameter int MAX_W = rkf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_H = rkf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic                           mode,
  input  logic [rkf_pkg::CH_W-1:0]       red_in,
  input  logic [rkf_pkg::CH_W-1:0]       green_in,
  input  logic [rkf_pkg::CH_W-1:0]       blue_in,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [rkf_pkg::CH_W-1:0]       red_out,
  input  logic [rkf_pkg::CH_W-1:0]       green_out,
  input  logic [rkf_pkg::CH_W-1:0]       blue_out,
  input  logic                           was_filtered,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [rkf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rkf_pkg::CFG_DATA_W-1:0] cfg_data,
  output int unsigned                    errors,
  output int unsigned                    outstanding,
  output int unsigned                    checked
);
  timeunit 1ns;
  timeprecision 1ps;

  import rkf_pkg::*;

  localparam int PRINT_LIMIT = 40;

  // Kernel weights, top-left first, and the divisor of each kernel
  localparam int WEIGHTS [4][TAPS] = '{
    '{0, -1, 0, -1, 5, -1, 0, -1, 0},
    '{-1, -1, -1, -1, 8, -1, -1, -1, -1},
    '{1, 1, 1, 1, 1, 1, 1, 1, 1},
    '{1, 2, 1, 2, 4, 2, 1, 2, 1}
  };
  localparam int NORM [4] = '{1, 1, 9, 16};

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            filtered;
  } out_pixel_t;

  out_pixel_t expected_pixels[$];

  // Register copies
  kernel_t              ks_cfg;
  logic [WIDTH_W-1:0]   width_cfg, xs_cfg, xe_cfg;
  logic [HEIGHT_W-1:0]  height_cfg, ys_cfg, ye_cfg;

  // Two rows above the input position, the 3x3 window, and positions
  pixel_t      row_above2 [MAX_W];
  pixel_t      row_above1 [MAX_W];
  pixel_t      win [TAPS];
  int unsigned in_col, in_row, out_col, out_row, backlog;

  function automatic int unsigned frame_width();
    if (width_cfg == 0) return 1;
    if (width_cfg > MAX_W) return MAX_W;
    return width_cfg;
  endfunction

  function automatic int unsigned frame_height();
    if (height_cfg == 0) return 1;
    if (height_cfg > MAX_H) return MAX_H;
    return height_cfg;
  endfunction

  // Step a raster position, wrapping at the width and the height
  function automatic void next_position(inout int unsigned col, inout int unsigned row);
    col++;
    if (col >= frame_width()) begin
      col = 0;
      row++;
      if (row >= frame_height()) row = 0;
    end
  endfunction

  // Rotate the line stores at the input column and shift the window left
  function automatic void shift_in(pixel_t px);
    int unsigned idx;
    pixel_t      up, mid;
    idx = (in_col >= MAX_W) ? 0 : in_col;
    up  = row_above2[idx];
    mid = row_above1[idx];
    row_above2[idx] = mid;
    row_above1[idx] = px;
    for (int r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = up;
    win[5] = mid;
    win[8] = px;
    next_position(in_col, in_row);
  endfunction

  // Weighted sum of one channel: zero if negative, else divide and limit
  function automatic logic [CH_W-1:0] channel_value(int unsigned shift);
    int sel;
    int acc;
    sel = int'(ks_cfg);
    acc = 0;
    for (int k = 0; k < TAPS; k++) begin
      acc += WEIGHTS[sel][k] * int'(win[k][shift +: CH_W]);
    end
    if (acc < 0) return '0;
    acc = acc / NORM[sel];
    return (acc > int'(CH_MAX)) ? CH_MAX : acc[CH_W-1:0];
  endfunction

  // Result for the window center at the output position
  function automatic out_pixel_t next_result();
    int unsigned w, h, xs, xe, ys, ye;
    logic        in_region;
    out_pixel_t  res;
    w  = frame_width();
    h  = frame_height();
    xs = (xs_cfg == 0) ? 1 : xs_cfg;
    xe = (xe_cfg >= w) ? w - 1 : xe_cfg;
    ys = (ys_cfg == 0) ? 1 : ys_cfg;
    ye = (ye_cfg >= h) ? h - 1 : ye_cfg;
    in_region = (out_col >= xs) && (out_col < xe) && (out_row >= ys) && (out_row < ye);
    if (in_region) begin
      res.red   = channel_value(2 * CH_W);
      res.green = channel_value(CH_W);
      res.blue  = channel_value(0);
    end else begin
      {res.red, res.green, res.blue} = win[4];
    end
    res.filtered = in_region;
    next_position(out_col, out_row);
    return res;
  endfunction

  // Work out what one accepted item releases
  function automatic void predict_item(logic kind, pixel_t px);
    int unsigned lag;
    lag = frame_width() + 1;
    if (kind == MODE_PIXEL) begin
      shift_in(px);
      if (backlog >= lag) begin
        backlog = lag;
        expected_pixels.push_back(next_result());
      end else begin
        backlog++;
      end
    end else if (backlog != 0) begin
      shift_in('0);
      expected_pixels.push_back(next_result());
      backlog--;
      if (backlog == 0) begin
        in_col = out_col;
        in_row = out_row;
      end
    end
  endfunction

  task automatic report_mismatch(string line);
    errors++;
    if (errors <= PRINT_LIMIT) $display("MISMATCH @%0t: %s", $time, line);
  endtask

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      report_mismatch($sformatf("output pixel %0d %s expected %0d got %0d",
                                checked, name, want, got));
    end
  endtask

  always @(posedge clk) begin
    out_pixel_t want;
    if (rst) begin
      ks_cfg     = KS_SHARPEN;
      width_cfg  = RST_IMAGE_WIDTH;
      height_cfg = RST_IMAGE_HEIGHT;
      xs_cfg     = '0;
      xe_cfg     = RST_REGION_X_END;
      ys_cfg     = '0;
      ye_cfg     = RST_REGION_Y_END;
      foreach (row_above2[i]) begin
        row_above2[i] = '0;
        row_above1[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
      backlog = 0;
      errors  = 0;
      checked = 0;
      expected_pixels.delete();
    end else begin
      // Register write
      if (cfg_valid && cfg_ready) begin
        case (reg_index_t'(cfg_index))
          REG_KERNEL_SELECT:  ks_cfg     = kernel_t'(cfg_data[KS_W-1:0]);
          REG_IMAGE_WIDTH:    width_cfg  = cfg_data[WIDTH_W-1:0];
          REG_IMAGE_HEIGHT:   height_cfg = cfg_data[HEIGHT_W-1:0];
          REG_REGION_X_START: xs_cfg     = cfg_data[WIDTH_W-1:0];
          REG_REGION_X_END:   xe_cfg     = cfg_data[WIDTH_W-1:0];
          REG_REGION_Y_START: ys_cfg     = cfg_data[HEIGHT_W-1:0];
          REG_REGION_Y_END:   ye_cfg     = cfg_data[HEIGHT_W-1:0];
          default: ;
        endcase
      end
      // Input transfer
      if (in_valid && !in_stall) predict_item(mode, {red_in, green_in, blue_in});
      // Output transfer against the oldest expectation
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("output pixel with nothing expected: %0d %0d %0d %0d",
                                    red_out, green_out, blue_out, was_filtered));
        end else begin
          want = expected_pixels.pop_front();
          compare_field("red", want.red, red_out);
          compare_field("green", want.green, green_out);
          compare_field("blue", want.blue, blue_out);
          compare_field("was_filtered", want.filtered, was_filtered);
          checked++;
        end
      end
    end
    outstanding = expected_pixels.size();
  end

endmodule

// ===== tb/rgb_3x3_kernel_filter_top_tb.sv =====
module rgb_3x3_kernel_filter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rkf_pkg::*;

  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int TARGET_PIXELS  = 800;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid, in_stall, mode;
  logic [CH_W-1:0]       red_in, green_in, blue_in;
  logic                  out_valid, out_stall;
  logic [CH_W-1:0]       red_out, green_out, blue_out;
  logic                  was_filtered;
  logic                  cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int unsigned errors, outstanding, checked;
  int unsigned idle_pct, stall_pct;
  int unsigned pixels_sent, flushes_sent, settings_used, random_pixels;
  int unsigned quiet_cycles;
  bit          hold_req;

  rgb_3x3_kernel_filter_top DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .red_in       (red_in),
    .green_in     (green_in),
    .blue_in      (blue_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .red_out      (red_out),
    .green_out    (green_out),
    .blue_out     (blue_out),
    .was_filtered (was_filtered),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  rkf_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .red_in       (red_in),
    .green_in     (green_in),
    .blue_in      (blue_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .red_out      (red_out),
    .green_out    (green_out),
    .blue_out     (blue_out),
    .was_filtered (was_filtered),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .outstanding  (outstanding),
    .checked      (checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: random stall, or a long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Count cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // Channel values lean toward the extremes
  function automatic logic [CH_W-1:0] chan_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return CH_MAX;
      default: return CH_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Region bound: mostly near the frame, sometimes anywhere in range
  function automatic int unsigned pick_bound(int unsigned near, int unsigned top);
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return top;
      2:       return $urandom_range(0, top);
      default: return $urandom_range(0, near + 1);
    endcase
  endfunction

  function automatic void set_idling(int unsigned sel);
    case (sel % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 59; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 59; end
      default: begin idle_pct = 19; stall_pct = 19; end
    endcase
  endfunction

  // Offer one item after a random gap and hold it until the transfer
  task automatic send_item(logic kind, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                           logic [CH_W-1:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= kind;
    red_in   <= r;
    green_in <= g;
    blue_in  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (kind == MODE_PIXEL) pixels_sent++;
    else flushes_sent++;
  endtask

  // Flush ticks carry random, ignored pixel fields
  task automatic drain(int unsigned n);
    repeat (n) send_item(MODE_FLUSH, chan_value(), chan_value(), chan_value());
  endtask

  // Drop valid, then wait until every expected pixel is out and the pipe is quiet
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(reg_index_t idx, int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_config(kernel_t ks, int unsigned w, int unsigned h, int unsigned xs,
                              int unsigned xe, int unsigned ys, int unsigned ye);
    wait_idle();
    put_reg(REG_KERNEL_SELECT, int'(ks));
    put_reg(REG_IMAGE_WIDTH, w);
    put_reg(REG_IMAGE_HEIGHT, h);
    put_reg(REG_REGION_X_START, xs);
    put_reg(REG_REGION_X_END, xe);
    put_reg(REG_REGION_Y_START, ys);
    put_reg(REG_REGION_Y_END, ye);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Whole frames of random pixels, then drain; narrow frames can get mid-frame drains
  task automatic run_frames(kernel_t ks, int unsigned w, int unsigned h, int unsigned xs,
                            int unsigned xe, int unsigned ys, int unsigned ye,
                            int unsigned frames, int hold_at);
    int idx;
    write_config(ks, w, h, xs, xe, ys, ye);
    idx = 0;
    repeat (frames * w * h) begin
      if (idx == hold_at) hold_req = 1'b1;
      if (w <= 16 && $urandom_range(0, 249) == 0) drain(w + 1);
      send_item(MODE_PIXEL, chan_value(), chan_value(), chan_value());
      idx++;
    end
    drain(w + 1 + $urandom_range(0, 2));
  endtask

  // 3x3 frame with a bright red, dark green center on the opposite
  // background: saturation on one channel, negative sum on another
  task automatic contrast_frame(kernel_t ks, bit extra_tick);
    write_config(ks, 3, 3, 0, RST_REGION_X_END, 0, RST_REGION_Y_END);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) send_item(MODE_PIXEL, CH_MAX, '0, chan_value());
      else send_item(MODE_PIXEL, '0, CH_MAX, chan_value());
    end
    drain(extra_tick ? 5 : 4);
  endtask

  initial begin
    int unsigned w, h, phase_no;
    rst       = 1'b1;
    in_valid  = 1'b0;
    mode      = MODE_PIXEL;
    red_in    = '0;
    green_in  = '0;
    blue_in   = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_KERNEL_SELECT;
    cfg_data  = '0;
    hold_req  = 1'b0;
    set_idling(0);
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed frames; the first ends with a tick that has nothing to drain
    contrast_frame(KS_SHARPEN, 1'b1);
    contrast_frame(KS_EDGE, 1'b0);

    // Wide rows with the receiver held off while the sender keeps offering
    run_frames(KS_GAUSS, 256, 3, 0, RST_REGION_X_END, 0, RST_REGION_Y_END, 1, 400);

    // Single-column tall frame, region starts at their maximum and ends at zero
    set_idling(3);
    run_frames(KS_BOX, 1, 200, RST_REGION_X_END, 0, RST_REGION_Y_END, 0, 1, -1);

    // Random settings with small frames
    phase_no = 0;
    random_pixels = pixels_sent;
    while (pixels_sent - random_pixels < TARGET_PIXELS) begin
      set_idling(phase_no);
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
      run_frames(kernel_t'($urandom_range(0, 3)), w, h,
                 pick_bound(w, RST_REGION_X_END), pick_bound(w, RST_REGION_X_END),
                 pick_bound(h, RST_REGION_Y_END), pick_bound(h, RST_REGION_Y_END),
                 $urandom_range(1, 3), -1);
      phase_no++;
    end

    wait_idle();
    $display("Sent %0d pixels and %0d flush ticks under %0d register settings, all kernels,",
             pixels_sent, flushes_sent, settings_used);
    $display("widths 1 to 256 and heights 1 to 200; %0d output pixels compared.", checked);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
